>>> rtl/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// shared types and constants of the face refinement stencil
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 56;
   localparam int CFG_W      = 7;
   localparam int ADDR_W     = 18;
   localparam int DELTA_W    = 32;
   localparam int VAL_W      = 32;
   localparam int SLOT_W     = 6;
   localparam int BLK_W      = 5;
   localparam int NSQ_W      = 14;
   localparam int LANES      = 4;

   localparam logic [CFG_W-1:0] CELLS_RESET = 7'd16;

   // lane arithmetic
   localparam int NUM_W       = 36;
   localparam int T_W         = 33;
   localparam int SPLIT       = 17;
   localparam int RECIP_SHIFT = 34;
   localparam logic [T_W-1:0] RECIP3 = 33'h1_5555_5556;
   localparam logic [T_W-1:0] T_CAP  = 33'h1_8000_0000;
   localparam logic [T_W-1:0] POS_MAX = 33'h0_7FFF_FFFF;
   localparam logic [T_W-1:0] NEG_MAG = 33'h0_8000_0000;

   // denominator codes
   localparam logic [1:0] DEN_HALF    = 2'd0;
   localparam logic [1:0] DEN_THIRD   = 2'd1;
   localparam logic [1:0] DEN_SIXTH   = 2'd2;
   localparam logic [1:0] DEN_TWELFTH = 2'd3;

   // interface kinds
   localparam logic [3:0] ACT_NORMAL    = 4'd0;
   localparam logic [3:0] ACT_FINE_FINE = 4'd1;
   localparam logic [3:0] ACT_CF_Q0     = 4'd2;
   localparam logic [3:0] ACT_CF_Q1     = 4'd3;
   localparam logic [3:0] ACT_CF_Q2     = 4'd4;
   localparam logic [3:0] ACT_CF_Q3     = 4'd5;
   localparam logic [3:0] ACT_COARSE    = 4'd6;
   localparam logic [3:0] ACT_FC_Q0     = 4'd7;
   localparam logic [3:0] ACT_FC_Q1     = 4'd8;
   localparam logic [3:0] ACT_FC_Q2     = 4'd9;
   localparam logic [3:0] ACT_FC_Q3     = 4'd10;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_ctl_type;

endpackage

>>> rtl/face_refinement_stencil.sv
// ----------------------------------------------------------------------------
// face_refinement_stencil
// turns one 2x2 block of Q16.16 face values into face buffer increments
// ----------------------------------------------------------------------------
// req channel: one beat per block, tuser carries the interface kind, tdata the
// slot, block coordinates and the four values. rsp channel: one beat per
// (address, delta) increment, tlast on the final increment of a block.
// csr channel: face width, to be written only while the block is idle; the
// block itself does not enforce it. A block enters an input register and
// passes four stages (operand set-up, rounding, reciprocal multiply,
// saturation) before its increments leave through the output register. New
// blocks can enter while the walker still emits an earlier block. The rsp
// channel carries one beat per cycle while rsp_tready is high. A block has 4
// increments for most kinds, 1 for fine-to-coarse and up to 16 for
// coarse-to-fine. Blocks with no increments leave no trace on rsp. While rsp
// is stalled the stages fill up and req_tready drops. Reset empties all
// stages and sets the face width to 16 cells.
// ----------------------------------------------------------------------------
module face_refinement_stencil import frs_pkg::*; #(
   parameter int MAX_CELLS  = 64,
   parameter int MAX_IFACES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // iface_slot, block_x, block_y, val_a, val_b, val_c, val_d
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [REQ_USER_W-1:0]   req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // address, delta, zero fill
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CFG_W-1:0]        csr_data
);

   localparam int TOP_CELLS = MAX_CELLS & ~1;

   typedef struct packed {
      logic [ADDR_W-1:0] origin;
      logic [LANES-1:0]  mask;
      logic              cf;
   } meta_type;

   function automatic logic [CFG_W-1:0] face_width(input logic [CFG_W-1:0] raw);
      logic [CFG_W-1:0] w;
      w = raw & 7'h7E;
      if (w < 7'd2) w = 7'd2;
      if (32'(w) > TOP_CELLS) w = CFG_W'(TOP_CELLS);
      return w;
   endfunction

   function automatic logic [1:0] lowest_bit(input logic [LANES-1:0] m);
      logic [1:0] r;
      if (m[0]) r = 2'd0;
      else if (m[1]) r = 2'd1;
      else if (m[2]) r = 2'd2;
      else r = 2'd3;
      return r;
   endfunction

   localparam logic [CFG_W-1:0] WIDTH_RESET = face_width(CELLS_RESET);
   localparam logic [1:0] LAST_COPY = 2'd3;

   // configuration
   logic [CFG_W-1:0] width_ff, width_in;
   logic [NSQ_W-1:0] nsq_ff, nsq_in;

   // stage valids and payload
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic v0_in, v1_in, v2_in, v3_in, v4_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic [REQ_USER_W-1:0] in_act_ff;
   meta_type meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta1_in;

   // emitter and output register
   logic [1:0] cur_i_ff, cur_i_in, cur_j_ff, cur_j_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, emit_addr;
   logic [DELTA_W-1:0] rsp_delta_ff;

   logic accept, out_free, fire, cur_last, take4;
   logic go0, go1, go2, go3, ready1, ready2, ready3, ready4;
   stage_ctl_type lane_ctl;

   // operand set-up
   logic [SLOT_W-1:0] slot;
   logic [BLK_W-1:0] bx, by;
   logic signed [VAL_W-1:0] val [LANES];
   logic signed [NUM_W-1:0] lane_num [LANES];
   logic [1:0] lane_den [LANES];
   logic [DELTA_W-1:0] lane_delta [LANES];
   logic signed [NUM_W-3:0] vsum;
   logic signed [NUM_W-1:0] v36;
   logic [5:0] half_w;
   logic [1:0] quad;
   logic [CFG_W-1:0] x0, y0;
   logic [CFG_W-1:0] col, row;
   logic [LANES-1:0] in_quad, mask;
   logic slot_ok, blk_ok;
   logic signed [8:0] xo, yo;
   logic [19:0] base_full;
   logic [ADDR_W-1:0] xext, yext, yn;
   logic [LANES-1:0] above;
   logic [1:0] dx, dy;
   logic [ADDR_W-1:0] offset;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      if (csr_valid) width_in = face_width(csr_data);
      nsq_in = NSQ_W'(width_in) * NSQ_W'(width_in);
   end

   // handshake chain
   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      fire     = v4_ff && out_free;
      take4    = fire && cur_last;
      ready4   = !v4_ff || take4;
      go3      = v3_ff && ready4;
      ready3   = !v3_ff || go3;
      go2      = v2_ff && ready3;
      ready2   = !v2_ff || go2;
      go1      = v1_ff && ready2;
      ready1   = !v1_ff || go1;
      go0      = v0_ff && ready1;
      req_tready = !v0_ff || go0;
      accept   = req_tvalid && req_tready;
      lane_ctl = '{ld1: go0, ld2: go1, ld3: go2, ld4: go3};

      v0_in = accept ? 1'b1 : (go0 ? 1'b0 : v0_ff);
      v1_in = go0 ? (mask != '0) : (go1 ? 1'b0 : v1_ff);
      v2_in = go1 ? 1'b1 : (go2 ? 1'b0 : v2_ff);
      v3_in = go2 ? 1'b1 : (go3 ? 1'b0 : v3_ff);
      v4_in = go3 ? 1'b1 : (take4 ? 1'b0 : v4_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // operand set-up from the input register
   always_comb begin
      slot   = in_data_ff[5:0];
      bx     = in_data_ff[10:6];
      by     = in_data_ff[15:11];
      v36    = '0;
      for (int i = 0; i < LANES; i++) begin
         val[i] = in_data_ff[16 + i*VAL_W +: VAL_W];
      end
      vsum   = (NUM_W-2)'(val[0]) + (NUM_W-2)'(val[1])
             + (NUM_W-2)'(val[2]) + (NUM_W-2)'(val[3]);
      half_w = width_ff[6:1];
      slot_ok = 32'(slot) < MAX_IFACES;
      blk_ok  = ({1'b0, bx, 1'b0} < width_ff) && ({1'b0, by, 1'b0} < width_ff);

      quad = 2'd0;
      case (in_act_ff)
         ACT_CF_Q0, ACT_CF_Q1, ACT_CF_Q2, ACT_CF_Q3: quad = 2'(in_act_ff - ACT_CF_Q0);
         ACT_FC_Q0, ACT_FC_Q1, ACT_FC_Q2, ACT_FC_Q3: quad = 2'(in_act_ff - ACT_FC_Q0);
         default: quad = 2'd0;
      endcase
      x0 = quad[0] ? {1'b0, half_w} : '0;
      y0 = quad[1] ? {1'b0, half_w} : '0;

      for (int i = 0; i < LANES; i++) begin
         col = {1'b0, bx, i[0]};
         row = {1'b0, by, i[1]};
         in_quad[i] = (col >= x0) && (col < x0 + {1'b0, half_w})
                   && (row >= y0) && (row < y0 + {1'b0, half_w});
         lane_num[i] = NUM_W'(val[i]);
         lane_den[i] = DEN_THIRD;
      end

      mask        = '0;
      meta1_in.cf = 1'b0;
      xo = 9'({bx, 1'b0});
      yo = 9'({by, 1'b0});
      case (in_act_ff)
         ACT_NORMAL: begin
            mask = 4'b1111;
            for (int i = 0; i < LANES; i++) lane_den[i] = DEN_HALF;
         end
         ACT_FINE_FINE: begin
            mask = 4'b1111;
            for (int i = 0; i < LANES; i++) begin
               v36 = NUM_W'(val[i]);
               lane_num[i] = (v36 <<< 3) + (v36 <<< 2) - NUM_W'(vsum);
               lane_den[i] = DEN_TWELFTH;
            end
         end
         ACT_CF_Q0, ACT_CF_Q1, ACT_CF_Q2, ACT_CF_Q3: begin
            mask = in_quad;
            meta1_in.cf = 1'b1;
            xo = 9'({bx, 2'b00}) - 9'({x0, 1'b0});
            yo = 9'({by, 2'b00}) - 9'({y0, 1'b0});
         end
         ACT_COARSE: begin
            mask = 4'b1111;
         end
         ACT_FC_Q0, ACT_FC_Q1, ACT_FC_Q2, ACT_FC_Q3: begin
            mask = 4'b0001;
            lane_num[0] = NUM_W'(vsum);
            lane_den[0] = DEN_SIXTH;
            xo = 9'(bx) + 9'(x0);
            yo = 9'(by) + 9'(y0);
         end
         default: mask = '0;
      endcase
      mask = mask & {LANES{slot_ok && blk_ok}};

      base_full = 20'(slot) * 20'(nsq_ff);
      xext = ADDR_W'(xo);
      yext = ADDR_W'(yo);
      yn   = yext * ADDR_W'(width_ff);
      meta1_in.origin = base_full[ADDR_W-1:0] + xext + yn;
      meta1_in.mask   = mask;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      frs_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .num   (lane_num[g]),
         .den   (lane_den[g]),
         .delta (lane_delta[g])
      );
   end

   // increment walker
   always_comb begin
      above    = meta4_ff.mask & 4'(4'b1110 << cur_i_ff);
      cur_last = (above == '0) && (!meta4_ff.cf || cur_j_ff == LAST_COPY);
      if (meta4_ff.cf) begin
         dx = {cur_i_ff[0], cur_j_ff[0]};
         dy = {cur_i_ff[1], cur_j_ff[1]};
      end else begin
         dx = {1'b0, cur_i_ff[0]};
         dy = {1'b0, cur_i_ff[1]};
      end
      offset = ADDR_W'(dx) + (dy[0] ? ADDR_W'(width_ff) : '0)
             + (dy[1] ? ADDR_W'({width_ff, 1'b0}) : '0);
      emit_addr = meta4_ff.origin + offset;

      cur_i_in = cur_i_ff;
      cur_j_in = cur_j_ff;
      if (go3) begin
         cur_i_in = lowest_bit(meta3_ff.mask);
         cur_j_in = 2'd0;
      end else if (fire && !cur_last) begin
         if (meta4_ff.cf && cur_j_ff != LAST_COPY) begin
            cur_j_in = cur_j_ff + 2'd1;
         end else begin
            cur_i_in = lowest_bit(above);
            cur_j_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         nsq_ff       <= NSQ_W'(WIDTH_RESET) * NSQ_W'(WIDTH_RESET);
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         cur_i_ff     <= 2'd0;
         cur_j_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         nsq_ff       <= nsq_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         cur_i_ff     <= cur_i_in;
         cur_j_ff     <= cur_j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_tdata;
         in_act_ff  <= req_tuser;
      end
      if (go0) meta1_ff <= meta1_in;
      if (go1) meta2_ff <= meta1_ff;
      if (go2) meta3_ff <= meta2_ff;
      if (go3) meta4_ff <= meta3_ff;
      if (fire) begin
         rsp_addr_ff  <= emit_addr;
         rsp_delta_ff <= lane_delta[cur_i_ff];
         rsp_last_ff  <= cur_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-ADDR_W-DELTA_W){1'b0}}, rsp_delta_ff, rsp_addr_ff};

   a_set_has_work: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> meta4_ff.mask != '0)
      else $error("walker holds a block with no increments");

   a_cursor_on_mask: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> meta4_ff.mask[cur_i_ff])
      else $error("walker cursor on a lane that does not emit");

   a_copy_only_upsample: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !meta4_ff.cf) |-> cur_j_ff == 2'd0)
      else $error("copy count moved outside upsampling");

   a_hold_until_last: assert property (@(posedge clock) disable iff (reset)
      (fire && !cur_last) |=> v4_ff)
      else $error("block dropped before its last beat");

   a_width_even: assert property (@(posedge clock) disable iff (reset)
      (!width_ff[0] && width_ff >= 7'd2))
      else $error("face width odd or below two");

endmodule

>>> rtl/frs_lane.sv
// ----------------------------------------------------------------------------
// frs_lane
// one delta lane: rounding, divide by a small constant, saturation
// ----------------------------------------------------------------------------
module frs_lane import frs_pkg::*; (
   input  logic                    clock,
   input  stage_ctl_type           ctl,
   input  logic signed [NUM_W-1:0] num,
   input  logic [1:0]              den,
   output logic [DELTA_W-1:0]      delta
);

   logic signed [NUM_W-1:0] num_ff;
   logic [1:0]              den_ff;

   logic [T_W-1:0]          t2_ff, t2_in;
   logic                    neg2_ff, third2_ff, third2_in;

   logic [T_W+SPLIT-1:0]        plo_ff, plo_in;
   logic [2*T_W-SPLIT-1:0]      phi_ff, phi_in;
   logic [T_W-1:0]              t3_ff;
   logic                        neg3_ff, third3_ff;

   logic [DELTA_W-1:0]      delta_ff, delta_in;

   logic [NUM_W-1:0]        mag;
   logic [NUM_W:0]          rnd, shifted;
   logic [3:0]              rnd_add;
   logic [1:0]              shift;
   logic [2*T_W-1:0]        prod;
   logic [T_W-1:0]          quo;

   // magnitude, round bias and pre-shift
   always_comb begin
      mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
      case (den_ff)
         DEN_HALF: begin
            rnd_add = 4'd1; shift = 2'd1; third2_in = 1'b0;
         end
         DEN_THIRD: begin
            rnd_add = 4'd1; shift = 2'd0; third2_in = 1'b1;
         end
         DEN_SIXTH: begin
            rnd_add = 4'd3; shift = 2'd1; third2_in = 1'b1;
         end
         default: begin
            rnd_add = 4'd6; shift = 2'd2; third2_in = 1'b1;
         end
      endcase
      rnd     = {1'b0, mag} + (NUM_W+1)'(rnd_add);
      shifted = rnd >> shift;
      t2_in   = (shifted > (NUM_W+1)'(T_CAP)) ? T_CAP : shifted[T_W-1:0];
   end

   // reciprocal multiply split in two partial products
   always_comb begin
      plo_in = (T_W+SPLIT)'(t2_ff) * (T_W+SPLIT)'(RECIP3[SPLIT-1:0]);
      phi_in = (2*T_W-SPLIT)'(t2_ff) * (2*T_W-SPLIT)'(RECIP3[T_W-1:SPLIT]);
   end

   always_comb begin
      prod = (2*T_W)'(plo_ff) + ((2*T_W)'(phi_ff) << SPLIT);
      quo  = third3_ff ? {1'b0, prod[RECIP_SHIFT +: DELTA_W]} : t3_ff;
      if (!neg3_ff) begin
         delta_in = (quo > POS_MAX) ? POS_MAX[DELTA_W-1:0] : quo[DELTA_W-1:0];
      end else begin
         delta_in = (quo >= NEG_MAG) ? NEG_MAG[DELTA_W-1:0] : DELTA_W'(-quo[DELTA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         num_ff <= num;
         den_ff <= den;
      end
      if (ctl.ld2) begin
         t2_ff     <= t2_in;
         neg2_ff   <= num_ff[NUM_W-1];
         third2_ff <= third2_in;
      end
      if (ctl.ld3) begin
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         t3_ff     <= t2_ff;
         neg3_ff   <= neg2_ff;
         third3_ff <= third2_ff;
      end
      if (ctl.ld4) begin
         delta_ff <= delta_in;
      end
   end

   assign delta = delta_ff;

endmodule

>>> tb/face_refinement_stencil_test.sv
// ----------------------------------------------------------------------------
// face_refinement_stencil_test
// self-checking bench for the face refinement stencil: a queue-fed driver
// sends 2x2 blocks, a local model predicts every (address, delta) increment,
// and a monitor compares each rsp beat in order; both sides stall at random
// but in the last two phases; the width changes between phases, when idle.
// ----------------------------------------------------------------------------
module face_refinement_stencil_test;
   import frs_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          NUM_PHASES   = 8;
   localparam int          PER_PHASE    = 14;
   localparam int          FACE_MAX     = 64;
   localparam logic [3:0]  ACT_UNUSED_LO = 4'd11;
   localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;
   localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q16_MIN = 32'h8000_0000;
   localparam longint      SAT_HI  = 64'sd2147483647;
   localparam longint      SAT_LO  = -64'sd2147483648;

   typedef struct {
      logic [3:0]        action;
      logic [SLOT_W-1:0] slot;
      logic [BLK_W-1:0]  bx;
      logic [BLK_W-1:0]  by;
      logic [31:0]       val [4];
   } block_type;

   typedef struct {
      logic [ADDR_W-1:0]  addr;
      logic [DELTA_W-1:0] delta;
      logic               last;
   } incr_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;

   block_type   block_queue [$];
   block_type   block_on_bus;
   incr_type    expected_incr [$];
   logic [6:0]  cells_per_side = CELLS_RESET;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          blocks_queued = 0;
   int          blocks_accepted = 0;
   int          incr_checked = 0;
   int          widths_tried = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   face_refinement_stencil DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned face_width(logic [6:0] raw);
      int unsigned w;
      w = 32'(raw & 7'h7E);
      if (w < 2) w = 2;
      if (w > FACE_MAX) w = FACE_MAX;
      return w;
   endfunction

   // nearest, ties away from zero, then clamp to 32 bits
   function automatic logic [31:0] round_q16(longint num, longint den);
      longint q;
      if (num >= 0) q = (num + den / 2) / den;
      else q = -((-num + den / 2) / den);
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      return q[31:0];
   endfunction

   function automatic incr_type incr_at(int unsigned addr, logic [31:0] delta);
      incr_type r;
      r.addr  = addr[ADDR_W-1:0];
      r.delta = delta;
      r.last  = 1'b0;
      return r;
   endfunction

   task automatic predict_increments(input block_type b);
      incr_type    burst [$];
      longint      v [4];
      longint      sum;
      int unsigned n, h, base, q, x0, y0, ox, oy, bx, by;
      int unsigned col [4];
      int unsigned row [4];
      logic [31:0] dv;
      n  = face_width(cells_per_side);
      bx = b.bx;
      by = b.by;
      if (2 * bx >= n || 2 * by >= n) return;
      base = b.slot * n * n;
      sum  = 0;
      for (int i = 0; i < 4; i++) begin
         v[i]   = longint'($signed(b.val[i]));
         sum   += v[i];
         col[i] = 2 * bx + (i & 1);
         row[i] = 2 * by + (i >> 1);
      end
      h = n / 2;
      case (b.action)
         ACT_NORMAL, ACT_COARSE: begin
            for (int i = 0; i < 4; i++)
               burst.push_back(incr_at(base + col[i] + row[i] * n,
                  round_q16(v[i], (b.action == ACT_NORMAL) ? 2 : 3)));
         end
         ACT_FINE_FINE: begin
            for (int i = 0; i < 4; i++)
               burst.push_back(incr_at(base + col[i] + row[i] * n,
                  round_q16(12 * v[i] - sum, 12)));
         end
         ACT_CF_Q0, ACT_CF_Q1, ACT_CF_Q2, ACT_CF_Q3: begin
            q  = b.action - ACT_CF_Q0;
            x0 = (q & 1) * h;
            y0 = (q >> 1) * h;
            for (int i = 0; i < 4; i++) begin
               if (col[i] < x0 || col[i] >= x0 + h) continue;
               if (row[i] < y0 || row[i] >= y0 + h) continue;
               ox = 2 * (col[i] - x0);
               oy = 2 * (row[i] - y0);
               dv = round_q16(v[i], 3);
               for (int j = 0; j < 4; j++)
                  burst.push_back(incr_at(base + ox + (j & 1) + (oy + (j >> 1)) * n, dv));
            end
         end
         ACT_FC_Q0, ACT_FC_Q1, ACT_FC_Q2, ACT_FC_Q3: begin
            q = b.action - ACT_FC_Q0;
            burst.push_back(incr_at(base + bx + (q & 1) * h + (by + (q >> 1) * h) * n,
               round_q16(sum, 6)));
         end
         default: ;
      endcase
      if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_incr.push_back(burst[i]);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      if (error_count < 40)
         $display("mismatch after %0d increments: %s got %0h want %0h",
            incr_checked, what, got, want);
      error_count++;
   endtask

   task automatic add_block(logic [3:0] act, int slot, int bx, int by,
                            logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
      block_type blk;
      blk.action = act;
      blk.slot   = SLOT_W'(slot);
      blk.bx     = BLK_W'(bx);
      blk.by     = BLK_W'(by);
      blk.val    = '{a, b, c, d};
      block_queue.push_back(blk);
      blocks_queued++;
   endtask

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(7))
         0: return Q16_MAX;
         1: return Q16_MIN;
         2: return 32'($urandom_range(6)) - 32'd3;
         3: return {{16{1'b0}}, 16'($urandom())} - 32'h0000_8000;
         default: return $urandom();
      endcase
   endfunction

   task automatic add_random(int wanted);
      int          useful;
      int unsigned n, bx, by;
      logic [3:0]  act;
      useful = 0;
      n = face_width(cells_per_side);
      while (useful < wanted) begin
         if ($urandom_range(19) == 0)
            act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
         else
            act = 4'($urandom_range(ACT_NORMAL, ACT_FC_Q3));
         bx = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(n / 2 - 1);
         by = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(n / 2 - 1);
         add_block(act, $urandom_range(63), bx, by,
                   rand_q16(), rand_q16(), rand_q16(), rand_q16());
         if (act <= ACT_FC_Q3 && 2 * bx < n && 2 * by < n) useful++;
      end
   endtask

   task automatic wait_drained();
      while (blocks_accepted != blocks_queued || expected_incr.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cells(logic [6:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cells_per_side = value;
      widths_tried++;
   endtask

   // req driver: one beat per block, valid held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_increments(block_on_bus);
            blocks_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (block_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               block_on_bus = block_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= block_on_bus.action;
               req_tdata  <= {block_on_bus.val[3], block_on_bus.val[2], block_on_bus.val[1],
                              block_on_bus.val[0], block_on_bus.by, block_on_bus.bx,
                              block_on_bus.slot};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor: each beat against the oldest predicted increment
   always @(posedge clock) begin
      incr_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_incr.size() == 0) begin
               report_mismatch("unexpected beat, address", rsp_tdata[ADDR_W-1:0], 0);
            end else begin
               want = expected_incr.pop_front();
               if (rsp_tdata[ADDR_W-1:0] !== want.addr)
                  report_mismatch("address", rsp_tdata[ADDR_W-1:0], want.addr);
               if (rsp_tdata[ADDR_W +: DELTA_W] !== want.delta)
                  report_mismatch("delta", rsp_tdata[ADDR_W +: DELTA_W], want.delta);
               if (rsp_tlast !== want.last)
                  report_mismatch("tlast", rsp_tlast, want.last);
               if (rsp_tdata[RSP_DATA_W-1:ADDR_W+DELTA_W] !== '0)
                  report_mismatch("fill bits", rsp_tdata[RSP_DATA_W-1:ADDR_W+DELTA_W], 0);
            end
            incr_checked++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d increments outstanding", expected_incr.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [6:0] phase_cells [NUM_PHASES];
      phase_cells = '{7'd64, 7'd2, 7'd6, 7'd127, 7'd13, 7'd0, 7'd30, 7'd16};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         if (ph < 3) begin
            send_idle_pct <= 8;
            recv_idle_pct <= 60;
         end else if (ph < 6) begin
            send_idle_pct <= 60;
            recv_idle_pct <= 8;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         write_cells(phase_cells[ph]);
         if (ph == 0) begin
            // widest face: corners, saturation and rounding ties
            add_block(ACT_NORMAL, 63, 31, 31, Q16_MAX, Q16_MIN, 32'd1, 32'hFFFF_FFFF);
            add_block(ACT_NORMAL, 0, 0, 0, 32'd0, 32'd3, 32'hFFFF_FFFD, 32'h0001_0000);
            add_block(ACT_FINE_FINE, 5, 3, 7, Q16_MAX, Q16_MAX, Q16_MIN, Q16_MIN);
            add_block(ACT_FINE_FINE, 9, 12, 2, 32'd6, 32'd0, 32'd0, 32'd0);
            add_block(ACT_FINE_FINE, 1, 30, 1, Q16_MIN, Q16_MAX, Q16_MAX, Q16_MAX);
            add_block(ACT_CF_Q0, 17, 0, 0, 32'd1, 32'd2, 32'd3, Q16_MAX);
            add_block(ACT_CF_Q1, 33, 16, 0, Q16_MIN, 32'hFFFF_FFFE, 32'd5, 32'd7);
            add_block(ACT_CF_Q2, 48, 0, 16, 32'h0003_0000, 32'd1, 32'd2, 32'hFFFF_FFFF);
            add_block(ACT_CF_Q3, 63, 31, 31, Q16_MAX, Q16_MIN, 32'd4, 32'hFFFF_FFFC);
            add_block(ACT_CF_Q0, 2, 31, 31, 32'd9, 32'd9, 32'd9, 32'd9);
            add_block(ACT_COARSE, 40, 10, 20, Q16_MAX, Q16_MIN, 32'd2, 32'hFFFF_FFFE);
            add_block(ACT_FC_Q0, 3, 0, 0, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX);
            add_block(ACT_FC_Q1, 62, 31, 0, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN);
            add_block(ACT_FC_Q2, 21, 0, 31, 32'd1, 32'd1, 32'd1, 32'd0);
            add_block(ACT_FC_Q3, 63, 31, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'd0);
            add_block(ACT_UNUSED_LO, 7, 1, 1, 32'd1, 32'd2, 32'd3, 32'd4);
            add_block(ACT_UNUSED_HI, 7, 1, 1, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX);
         end
         if (face_width(cells_per_side) == 6) begin
            // odd half width: quadrants cut through blocks, plus blocks off the face
            add_block(ACT_CF_Q1, 11, 1, 0, 32'd3, 32'd6, 32'd9, 32'd12);
            add_block(ACT_CF_Q3, 12, 1, 1, 32'd3, 32'd6, 32'd9, 32'd12);
            add_block(ACT_CF_Q0, 13, 1, 1, 32'd3, 32'd6, 32'd9, 32'd12);
            add_block(ACT_CF_Q2, 14, 1, 0, 32'd3, 32'd6, 32'd9, 32'd12);
            add_block(ACT_NORMAL, 15, 3, 0, 32'd1, 32'd1, 32'd1, 32'd1);
            add_block(ACT_FC_Q0, 16, 0, 3, 32'd1, 32'd1, 32'd1, 32'd1);
         end
         add_random(PER_PHASE);
      end
      wait_drained();
      if (expected_incr.size() != 0)
         report_mismatch("increments never seen", expected_incr.size(), 0);
      $display("sent %0d blocks across %0d face width settings", blocks_accepted, widths_tried);
      $display("checked %0d increments, %0d mismatches", incr_checked, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
